FILE: sv/dmcc_pkg.sv
// shared types and constants for the dual motor command controller
package dmcc_pkg;

  localparam int unsigned DUTY_BITS = 10;
  localparam int unsigned SPEED_BITS = 8;
  localparam int unsigned IDLE_BITS = 16;

  localparam logic [1:0] CMD_COMMAND = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_SPEEDS = 2'd2;

  localparam logic [3:0] CODE_ESTOP = 4'd0;
  localparam logic [3:0] CODE_STOP = 4'd1;
  localparam logic [3:0] CODE_SET_MANUAL = 4'd2;
  localparam logic [3:0] CODE_SET_AUTO = 4'd3;
  localparam logic [3:0] CODE_FWD = 4'd4;
  localparam logic [3:0] CODE_BACK = 4'd5;
  localparam logic [3:0] CODE_LEFT = 4'd6;
  localparam logic [3:0] CODE_RIGHT = 4'd7;

  localparam logic [1:0] DIR_OFF = 2'd0;
  localparam logic [1:0] DIR_REV = 2'd1;
  localparam logic [1:0] DIR_FWD = 2'd2;

  localparam logic [1:0] STATUS_STOPPED = 2'd0;
  localparam logic [1:0] STATUS_ESTOP = 2'd1;
  localparam logic [1:0] STATUS_MOVING = 2'd2;

  localparam logic [1:0] REG_DUTY_MAX = 2'd0;
  localparam logic [1:0] REG_MAX_STEP = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    OP_COMMAND,
    OP_TICK,
    OP_SPEEDS,
    OP_NOP
  } op_kind_e;

  typedef struct packed {
    op_kind_e              kind;
    logic [3:0]            code;
    logic [SPEED_BITS-1:0] value;
    logic [SPEED_BITS-1:0] left_target;
    logic [SPEED_BITS-1:0] right_target;
  } op_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0]  duty_max;
    logic [SPEED_BITS-1:0] max_step;
    logic [IDLE_BITS-1:0]  timeout_ticks;
  } cfg_t;

endpackage

FILE: sv/dual_motor_command_controller.sv
// top level: configuration registers, front end, back end
// path: a push is written into the operation queue, then executed into the result register, from which it is popped
// throughput: one transaction per cycle, set by the execute step, while the result register is empty or being popped
// the two-entry operation queue and the result register decouple push and pop
// reset: drive state, speeds, idle counter and latch clear to zero; queues empty
// registers reset to duty_max 1023, max_step 10, timeout_ticks 500
module dual_motor_command_controller import dmcc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            cmd_i,
  input  logic [3:0]            code_i,
  input  logic [SPEED_BITS-1:0] value_i,
  input  logic [SPEED_BITS-1:0] left_target_i,
  input  logic [SPEED_BITS-1:0] right_target_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [DUTY_BITS-1:0]  left_duty_o,
  output logic [DUTY_BITS-1:0]  right_duty_o,
  output logic [1:0]            left_dir_o,
  output logic [1:0]            right_dir_o,
  output logic [1:0]            status_o,
  output logic [SPEED_BITS-1:0] auto_speed_o
);

  cfg_t       cfg_q;
  logic       cfg_wr;
  logic [1:0] reg_sel;
  logic       op_valid;
  logic       op_ready;
  op_t        op;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_max <= DUTY_BITS'(1023);
      cfg_q.max_step <= SPEED_BITS'(10);
      cfg_q.timeout_ticks <= IDLE_BITS'(500);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_DUTY_MAX: cfg_q.duty_max <= pwdata[DUTY_BITS-1:0];
        REG_MAX_STEP: cfg_q.max_step <= pwdata[SPEED_BITS-1:0];
        REG_TIMEOUT:  cfg_q.timeout_ticks <= pwdata[IDLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DUTY_MAX: prdata = 32'(cfg_q.duty_max);
      REG_MAX_STEP: prdata = 32'(cfg_q.max_step);
      REG_TIMEOUT:  prdata = 32'(cfg_q.timeout_ticks);
      default:      prdata = '0;
    endcase
  end

  dmcc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .cmd_i          (cmd_i),
    .code_i         (code_i),
    .value_i        (value_i),
    .left_target_i  (left_target_i),
    .right_target_i (right_target_i),
    .op_valid_o     (op_valid),
    .op_o           (op),
    .op_ready_i     (op_ready)
  );

  dmcc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .op_valid_i   (op_valid),
    .op_i         (op),
    .op_ready_o   (op_ready),
    .empty        (empty),
    .pop          (pop),
    .left_duty_o  (left_duty_o),
    .right_duty_o (right_duty_o),
    .left_dir_o   (left_dir_o),
    .right_dir_o  (right_dir_o),
    .status_o     (status_o),
    .auto_speed_o (auto_speed_o)
  );

  a_latched_dirs_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == STATUS_ESTOP) |-> (left_dir_o == DIR_OFF && right_dir_o == DIR_OFF))
    else $error("direction pins active while emergency stop is latched");

  a_dirs_paired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((left_dir_o == DIR_OFF) == (right_dir_o == DIR_OFF)))
    else $error("only one motor side is switched off");

  a_dir_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (left_dir_o != 2'd3 && right_dir_o != 2'd3))
    else $error("both direction pins driven high");

endmodule

FILE: sv/dmcc_front.sv
// front end: classifies incoming transactions into a two-entry operation queue
module dmcc_front import dmcc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            cmd_i,
  input  logic [3:0]            code_i,
  input  logic [SPEED_BITS-1:0] value_i,
  input  logic [SPEED_BITS-1:0] left_target_i,
  input  logic [SPEED_BITS-1:0] right_target_i,
  output logic                  op_valid_o,
  output op_t                   op_o,
  input  logic                  op_ready_i
);

  op_t        slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;
  op_t        op_in;

  always_comb begin
    unique case (cmd_i)
      CMD_COMMAND: op_in.kind = OP_COMMAND;
      CMD_TICK:    op_in.kind = OP_TICK;
      CMD_SPEEDS:  op_in.kind = OP_SPEEDS;
      default:     op_in.kind = OP_NOP;
    endcase
    op_in.code = code_i;
    op_in.value = value_i;
    op_in.left_target = left_target_i;
    op_in.right_target = right_target_i;
  end

  assign full = (count_q == 2'd2);
  assign do_push = push && !full;
  assign op_valid_o = (count_q != 2'd0);
  assign do_pop = op_valid_o && op_ready_i;
  assign op_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= op_in;
    end
  end

endmodule

FILE: sv/dmcc_back.sv
// back end: executes operations against the drive state and registers the result
module dmcc_back import dmcc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  op_valid_i,
  input  op_t                   op_i,
  output logic                  op_ready_o,
  output logic                  empty,
  input  logic                  pop,
  output logic [DUTY_BITS-1:0]  left_duty_o,
  output logic [DUTY_BITS-1:0]  right_duty_o,
  output logic [1:0]            left_dir_o,
  output logic [1:0]            right_dir_o,
  output logic [1:0]            status_o,
  output logic [SPEED_BITS-1:0] auto_speed_o
);

  localparam int unsigned ProdW = SPEED_BITS + DUTY_BITS;
  localparam int unsigned ScaledW = ProdW + 9;

  // speed * duty_max / 255 via reciprocal 257/65536 and one correction step
  function automatic logic [DUTY_BITS-1:0] speed_to_duty(
    input logic [SPEED_BITS-1:0] speed,
    input logic [DUTY_BITS-1:0]  dmax
  );
    logic [ProdW-1:0]   prod;
    logic [ScaledW-1:0] scaled;
    logic [ProdW-1:0]   quot;
    logic [ProdW-1:0]   rem;
    prod = ProdW'(speed) * ProdW'(dmax);
    scaled = {ScaledW'(prod) << 8} + ScaledW'(prod);
    quot = ProdW'(scaled >> 16);
    rem = prod - ((quot << 8) - quot);
    if (rem >= ProdW'(255)) begin
      quot = quot + ProdW'(1);
    end
    return quot[DUTY_BITS-1:0];
  endfunction

  function automatic logic [SPEED_BITS-1:0] slew(
    input logic [SPEED_BITS-1:0] cur,
    input logic [SPEED_BITS-1:0] tgt,
    input logic [SPEED_BITS-1:0] step
  );
    logic [SPEED_BITS-1:0] diff;
    diff = (cur > tgt) ? (cur - tgt) : (tgt - cur);
    if (diff <= step) begin
      return tgt;
    end
    return (cur < tgt) ? (cur + step) : (cur - step);
  endfunction

  logic                  estop_q, estop_d;
  logic [SPEED_BITS-1:0] manual_q, manual_d;
  logic [SPEED_BITS-1:0] auto_q, auto_d;
  logic [SPEED_BITS-1:0] cur_left_q, cur_left_d;
  logic [SPEED_BITS-1:0] cur_right_q, cur_right_d;
  logic [IDLE_BITS-1:0]  idle_q, idle_d;
  logic [DUTY_BITS-1:0]  ld_q, ld_d;
  logic [DUTY_BITS-1:0]  rd_q, rd_d;
  logic [1:0]            ldir_q, ldir_d;
  logic [1:0]            rdir_q, rdir_d;
  logic                  out_valid_q, out_valid_d;
  logic [1:0]            status_q, status_d;
  logic                  take;
  logic [DUTY_BITS-1:0]  duty_in;
  logic [DUTY_BITS-1:0]  duty_a, duty_b;
  logic [SPEED_BITS-1:0] slew_left, slew_right;

  assign op_ready_o = !out_valid_q || pop;
  assign take = op_valid_i && op_ready_o;
  assign empty = !out_valid_q;

  assign slew_left = slew(cur_left_q, op_i.left_target, cfg_i.max_step);
  assign slew_right = slew(cur_right_q, op_i.right_target, cfg_i.max_step);

  always_comb begin
    duty_in = speed_to_duty(manual_q, cfg_i.duty_max);
    duty_a = duty_in;
    duty_b = speed_to_duty(slew_right, cfg_i.duty_max);
    if (op_i.kind == OP_SPEEDS) begin
      duty_a = speed_to_duty(slew_left, cfg_i.duty_max);
    end
  end

  always_comb begin
    estop_d = estop_q;
    manual_d = manual_q;
    auto_d = auto_q;
    cur_left_d = cur_left_q;
    cur_right_d = cur_right_q;
    idle_d = idle_q;
    ld_d = ld_q;
    rd_d = rd_q;
    ldir_d = ldir_q;
    rdir_d = rdir_q;
    if (take) begin
      case (op_i.kind)
        OP_COMMAND: begin
          idle_d = '0;
          if (op_i.code == CODE_ESTOP) begin
            estop_d = 1'b1;
            ld_d = '0;
            rd_d = '0;
            ldir_d = DIR_OFF;
            rdir_d = DIR_OFF;
          end else if (!estop_q || op_i.code == CODE_STOP) begin
            unique case (op_i.code)
              CODE_STOP: begin
                estop_d = 1'b0;
                ld_d = '0;
                rd_d = '0;
                ldir_d = DIR_OFF;
                rdir_d = DIR_OFF;
              end
              CODE_SET_MANUAL: manual_d = op_i.value;
              CODE_SET_AUTO:   auto_d = op_i.value;
              CODE_FWD: begin
                ld_d = duty_a;
                rd_d = duty_a;
                ldir_d = DIR_FWD;
                rdir_d = DIR_FWD;
              end
              CODE_BACK: begin
                ld_d = duty_a;
                rd_d = duty_a;
                ldir_d = DIR_REV;
                rdir_d = DIR_REV;
              end
              CODE_LEFT: begin
                ld_d = duty_a >> 1;
                rd_d = duty_a;
                ldir_d = DIR_REV;
                rdir_d = DIR_FWD;
              end
              CODE_RIGHT: begin
                ld_d = duty_a;
                rd_d = duty_a >> 1;
                ldir_d = DIR_FWD;
                rdir_d = DIR_REV;
              end
              default: ;
            endcase
          end
        end
        OP_TICK: begin
          if (idle_q != '1) begin
            idle_d = idle_q + IDLE_BITS'(1);
          end
          if (idle_d >= cfg_i.timeout_ticks && !estop_q) begin
            ld_d = '0;
            rd_d = '0;
            ldir_d = DIR_OFF;
            rdir_d = DIR_OFF;
          end
        end
        OP_SPEEDS: begin
          cur_left_d = slew_left;
          cur_right_d = slew_right;
          ld_d = duty_a;
          rd_d = duty_b;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (estop_d) begin
      status_d = STATUS_ESTOP;
    end else if (cur_left_d != '0 || cur_right_d != '0) begin
      status_d = STATUS_MOVING;
    end else begin
      status_d = STATUS_STOPPED;
    end
    out_valid_d = take || (out_valid_q && !pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      estop_q <= 1'b0;
      manual_q <= '0;
      auto_q <= '0;
      cur_left_q <= '0;
      cur_right_q <= '0;
      idle_q <= '0;
      ld_q <= '0;
      rd_q <= '0;
      ldir_q <= DIR_OFF;
      rdir_q <= DIR_OFF;
      out_valid_q <= 1'b0;
      status_q <= STATUS_STOPPED;
    end else begin
      estop_q <= estop_d;
      manual_q <= manual_d;
      auto_q <= auto_d;
      cur_left_q <= cur_left_d;
      cur_right_q <= cur_right_d;
      idle_q <= idle_d;
      ld_q <= ld_d;
      rd_q <= rd_d;
      ldir_q <= ldir_d;
      rdir_q <= rdir_d;
      out_valid_q <= out_valid_d;
      if (take) begin
        status_q <= status_d;
      end
    end
  end

  assign left_duty_o = ld_q;
  assign right_duty_o = rd_q;
  assign left_dir_o = ldir_q;
  assign right_dir_o = rdir_q;
  assign status_o = status_q;
  assign auto_speed_o = auto_q;

endmodule
